[src/aabb_collision_push_out_core_defines.svh]
// Assertion macros for the box push-out block
`ifndef AABB_COLLISION_PUSH_OUT_CORE_DEFINES_SVH
`define AABB_COLLISION_PUSH_OUT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define AABB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/aabb_pkg.sv]
// Shared types and constants for the box push-out block
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam int FIELD_W    = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_OUT_W  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELF_BOX_MIN      = 3'd0,
        CFG_SELF_BOX_MAX      = 3'd1,
        CFG_SELF_SCALE        = 3'd2,
        CFG_SELF_POSITION     = 3'd3,
        CFG_SELF_HAS_COLLIDER = 3'd4,
        CFG_SELF_IS_WALL      = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic hit_en;
        logic push_en;
    } flags_t;

endpackage

`default_nettype wire

[src/aabb_if.sv]
// Channel interfaces for object words and result words
`timescale 1ns / 1ps
`default_nettype none

interface aabb_in_if import aabb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FIELD_W-1:0]  other_box_min;
    logic [FIELD_W-1:0]  other_box_max;
    logic [FIELD_W-1:0]  other_scale;
    logic [FIELD_W-1:0]  other_position;
    logic                other_has_collider;
    logic                other_is_wall;
    logic                other_is_self;

    modport source (
        output valid, other_box_min, other_box_max, other_scale, other_position,
               other_has_collider, other_is_wall, other_is_self,
        input  ready
    );
    modport sink (
        input  valid, other_box_min, other_box_max, other_scale, other_position,
               other_has_collider, other_is_wall, other_is_self,
        output ready
    );
endinterface

interface aabb_out_if import aabb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic                        pushed;
    logic [1:0]                  push_axis;
    logic signed [POS_OUT_W-1:0] new_pos_x;
    logic signed [POS_OUT_W-1:0] new_pos_y;
    logic signed [POS_OUT_W-1:0] new_pos_z;

    modport source (
        output valid, hit, pushed, push_axis, new_pos_x, new_pos_y, new_pos_z,
        input  ready
    );
    modport sink (
        input  valid, hit, pushed, push_axis, new_pos_x, new_pos_y, new_pos_z,
        output ready
    );
endinterface

`default_nettype wire

[src/aabb_xform.sv]
// Local-to-world box transform: scale multiply, then floor shift and offset
`timescale 1ns / 1ps
`default_nettype none

module aabb_xform import aabb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            en1,
    input  wire logic                            en2,
    input  wire logic [FIELD_W-1:0]              box_min,
    input  wire logic [FIELD_W-1:0]              box_max,
    input  wire logic [FIELD_W-1:0]              scale,
    input  wire logic [FIELD_W-1:0]              position,
    output logic signed [2*COORD_BITS-8:0]       wmin [3],
    output logic signed [2*COORD_BITS-8:0]       wmax [3],
    output logic signed [COORD_BITS-1:0]         pos  [3]
);

    localparam int PAD_W   = (3 * COORD_BITS > FIELD_W) ? 3 * COORD_BITS : FIELD_W;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int WORLD_W = 2 * COORD_BITS - 7;

    logic [PAD_W-1:0] min_pad;
    logic [PAD_W-1:0] max_pad;
    logic [PAD_W-1:0] scale_pad;
    logic [PAD_W-1:0] pos_pad;

    logic signed [COORD_BITS-1:0] min_c   [3];
    logic signed [COORD_BITS-1:0] max_c   [3];
    logic signed [COORD_BITS-1:0] scale_c [3];
    logic signed [COORD_BITS-1:0] pos_c   [3];

    logic signed [PROD_W-1:0]     prod_min_reg [3];
    logic signed [PROD_W-1:0]     prod_max_reg [3];
    logic signed [COORD_BITS-1:0] pos1_reg     [3];

    logic signed [SHIFT_W-1:0]    shr_min [3];
    logic signed [SHIFT_W-1:0]    shr_max [3];

    logic signed [WORLD_W-1:0]    wmin_reg [3];
    logic signed [WORLD_W-1:0]    wmax_reg [3];
    logic signed [COORD_BITS-1:0] pos2_reg [3];

    assign min_pad   = PAD_W'(box_min);
    assign max_pad   = PAD_W'(box_max);
    assign scale_pad = PAD_W'(scale);
    assign pos_pad   = PAD_W'(position);

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        assign min_c[i]   = min_pad[i*COORD_BITS +: COORD_BITS];
        assign max_c[i]   = max_pad[i*COORD_BITS +: COORD_BITS];
        assign scale_c[i] = scale_pad[i*COORD_BITS +: COORD_BITS];
        assign pos_c[i]   = pos_pad[i*COORD_BITS +: COORD_BITS];
        assign shr_min[i] = prod_min_reg[i][PROD_W-1:FRAC_BITS];
        assign shr_max[i] = prod_max_reg[i][PROD_W-1:FRAC_BITS];
        assign wmin[i]    = wmin_reg[i];
        assign wmax[i]    = wmax_reg[i];
        assign pos[i]     = pos2_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_min_reg[i] <= min_c[i] * scale_c[i];
                prod_max_reg[i] <= max_c[i] * scale_c[i];
                pos1_reg[i]     <= pos_c[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wmin_reg[i] <= WORLD_W'(shr_min[i]) + WORLD_W'(pos1_reg[i]);
                wmax_reg[i] <= WORLD_W'(shr_max[i]) + WORLD_W'(pos1_reg[i]);
                pos2_reg[i] <= pos1_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

[src/aabb_ovl.sv]
// Overlap test, face overlaps, centre compare and per-axis smallest face
`timescale 1ns / 1ps
`default_nettype none

module aabb_ovl import aabb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            en3,
    input  wire logic                            en4,
    input  wire flags_t                          flags,
    input  wire logic signed [2*COORD_BITS-8:0]  smin [3],
    input  wire logic signed [2*COORD_BITS-8:0]  smax [3],
    input  wire logic signed [2*COORD_BITS-8:0]  omin [3],
    input  wire logic signed [2*COORD_BITS-8:0]  omax [3],
    input  wire logic signed [COORD_BITS-1:0]    pos_in [3],
    output logic signed [2*COORD_BITS-7:0]       best [3],
    output logic                                 cgt  [3],
    output logic                                 hit,
    output logic                                 push,
    output logic signed [COORD_BITS-1:0]         pos_out [3]
);

    localparam int WORLD_W = 2 * COORD_BITS - 7;
    localparam int DIFF_W  = WORLD_W + 1;

    logic                         sep;
    logic signed [DIFF_W-1:0]     ovp_reg  [3];
    logic signed [DIFF_W-1:0]     ovn_reg  [3];
    logic signed [DIFF_W-1:0]     osum_reg [3];
    logic signed [DIFF_W-1:0]     ssum_reg [3];
    logic                         hit3_reg;
    logic                         push_en3_reg;
    logic signed [COORD_BITS-1:0] pos3_reg [3];

    logic signed [DIFF_W-1:0]     best4_reg [3];
    logic                         cgt4_reg  [3];
    logic                         hit4_reg;
    logic                         push4_reg;
    logic signed [COORD_BITS-1:0] pos4_reg  [3];

    always_comb
    begin
        sep = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (smax[i] < omin[i] || smin[i] > omax[i])
                sep = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ovp_reg[i]  <= DIFF_W'(smax[i]) - DIFF_W'(omin[i]);
                ovn_reg[i]  <= DIFF_W'(omax[i]) - DIFF_W'(smin[i]);
                osum_reg[i] <= DIFF_W'(omin[i]) + DIFF_W'(omax[i]);
                ssum_reg[i] <= DIFF_W'(smin[i]) + DIFF_W'(smax[i]);
                pos3_reg[i] <= pos_in[i];
            end
            hit3_reg     <= flags.hit_en && !sep;
            push_en3_reg <= flags.push_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                best4_reg[i] <= (ovn_reg[i] < ovp_reg[i]) ? ovn_reg[i] : ovp_reg[i];
                cgt4_reg[i]  <= osum_reg[i] > ssum_reg[i];
                pos4_reg[i]  <= pos3_reg[i];
            end
            hit4_reg  <= hit3_reg;
            push4_reg <= hit3_reg && push_en3_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign best[i]    = best4_reg[i];
        assign cgt[i]     = cgt4_reg[i];
        assign pos_out[i] = pos4_reg[i];
    end

    assign hit  = hit4_reg;
    assign push = push4_reg;

endmodule

`default_nettype wire

[src/aabb_push.sv]
// Axis choice, position correction and saturation into the result register
`timescale 1ns / 1ps
`default_nettype none

module aabb_push import aabb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            en5,
    input  wire logic                            en6,
    input  wire logic signed [2*COORD_BITS-7:0]  best [3],
    input  wire logic                            cgt  [3],
    input  wire logic                            hit_in,
    input  wire logic                            push_in,
    input  wire logic signed [COORD_BITS-1:0]    pos_in [3],
    output logic                                 hit,
    output logic                                 pushed,
    output axis_t                                push_axis,
    output logic signed [POS_OUT_W-1:0]          new_pos_x,
    output logic signed [POS_OUT_W-1:0]          new_pos_y,
    output logic signed [POS_OUT_W-1:0]          new_pos_z
);

    localparam int DIFF_W = 2 * COORD_BITS - 6;
    localparam int SUM_W  = DIFF_W + 1;
    localparam int EXT_W  = (COORD_BITS > POS_OUT_W) ? COORD_BITS : POS_OUT_W;

    logic signed [DIFF_W-1:0]     sel_mag;
    axis_t                        sel_axis;
    logic                         sel_up;

    logic signed [DIFF_W-1:0]     mag5_reg;
    axis_t                        axis5_reg;
    logic                         up5_reg;
    logic                         hit5_reg;
    logic                         push5_reg;
    logic signed [COORD_BITS-1:0] pos5_reg [3];

    logic signed [SUM_W-1:0]      sum      [3];
    logic signed [COORD_BITS-1:0] sat_val  [3];
    logic signed [EXT_W-1:0]      ext_val  [3];

    logic                         hit6_reg;
    logic                         pushed6_reg;
    axis_t                        axis6_reg;
    logic signed [POS_OUT_W-1:0]  pos6_reg [3];

    always_comb
    begin
        sel_mag  = best[0];
        sel_axis = AXIS_X;
        if (best[1] < sel_mag)
        begin
            sel_mag  = best[1];
            sel_axis = AXIS_Y;
        end
        if (best[2] < sel_mag)
        begin
            sel_mag  = best[2];
            sel_axis = AXIS_Z;
        end
        case (sel_axis)
            AXIS_X:  sel_up = cgt[0];
            AXIS_Y:  sel_up = cgt[1];
            AXIS_Z:  sel_up = cgt[2];
            default: sel_up = cgt[0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            mag5_reg  <= sel_mag;
            axis5_reg <= push_in ? sel_axis : AXIS_X;
            up5_reg   <= sel_up;
            hit5_reg  <= hit_in;
            push5_reg <= push_in;
            for (int i = 0; i < 3; i++)
                pos5_reg[i] <= pos_in[i];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        always_comb
        begin
            if (push5_reg && axis5_reg == axis_t'(i))
                sum[i] = up5_reg ? SUM_W'(pos5_reg[i]) + SUM_W'(mag5_reg)
                                 : SUM_W'(pos5_reg[i]) - SUM_W'(mag5_reg);
            else
                sum[i] = SUM_W'(pos5_reg[i]);
            if (sum[i][SUM_W-1:COORD_BITS-1] == {(SUM_W-COORD_BITS+1){sum[i][SUM_W-1]}})
                sat_val[i] = sum[i][COORD_BITS-1:0];
            else
                sat_val[i] = {sum[i][SUM_W-1], {(COORD_BITS-1){~sum[i][SUM_W-1]}}};
            ext_val[i] = EXT_W'(sat_val[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            hit6_reg    <= hit5_reg;
            pushed6_reg <= push5_reg;
            axis6_reg   <= axis5_reg;
            for (int i = 0; i < 3; i++)
                pos6_reg[i] <= ext_val[i][POS_OUT_W-1:0];
        end
    end

    assign hit       = hit6_reg;
    assign pushed    = pushed6_reg;
    assign push_axis = axis6_reg;
    assign new_pos_x = pos6_reg[0];
    assign new_pos_y = pos6_reg[1];
    assign new_pos_z = pos6_reg[2];

endmodule

`default_nettype wire

[src/aabb_collision_push_out_core.sv]
// Top level of the box collision and push-out pipeline
// Usage:
//   Write the fixed box through cfg_we / cfg_index / cfg_data while no word
//   is in flight: local min, max, scale, position (packed x,y,z Q8.8), then
//   the collider and wall flags. Unknown indexes are ignored.
//   Each word on the item channel is one scene object; the result channel
//   returns exactly one word per object, in order: hit, pushed, push_axis
//   and the corrected, saturated position.
//   Six registered stages lie between acceptance and result valid: two for the
//   scale multiply and world offset, two for overlap and per-axis face
//   minimum, two for axis choice and saturated correction.
//   Throughput is one word per cycle while result.ready stays high; every
//   stage has its own valid bit and advances whenever its next stage is
//   empty or advancing, so bubbles are squeezed out.
//   When the receiver stalls, the result word holds and upstream stages keep
//   filling; item.ready drops only once all six stages hold words.
//   Reset clears the configuration to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "aabb_collision_push_out_core_defines.svh"

module aabb_collision_push_out_core import aabb_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    aabb_in_if.sink                    item,
    aabb_out_if.source                 result
);

    localparam int WORLD_W = 2 * COORD_BITS - 7;
    localparam int DIFF_W  = WORLD_W + 1;

    logic [FIELD_W-1:0] cfg_min_reg;
    logic [FIELD_W-1:0] cfg_max_reg;
    logic [FIELD_W-1:0] cfg_scale_reg;
    logic [FIELD_W-1:0] cfg_pos_reg;
    logic               cfg_collider_reg;
    logic               cfg_wall_reg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    flags_t flags_in;
    flags_t flags1_reg;
    flags_t flags2_reg;

    logic signed [WORLD_W-1:0]    smin [3];
    logic signed [WORLD_W-1:0]    smax [3];
    logic signed [COORD_BITS-1:0] spos [3];
    logic signed [WORLD_W-1:0]    omin [3];
    logic signed [WORLD_W-1:0]    omax [3];
    logic signed [COORD_BITS-1:0] opos [3];

    logic signed [DIFF_W-1:0]     best [3];
    logic                         cgt  [3];
    logic                         hit4;
    logic                         push4;
    logic signed [COORD_BITS-1:0] pos4 [3];

    axis_t axis_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_min_reg      <= '0;
            cfg_max_reg      <= '0;
            cfg_scale_reg    <= '0;
            cfg_pos_reg      <= '0;
            cfg_collider_reg <= 1'b0;
            cfg_wall_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELF_BOX_MIN:      cfg_min_reg      <= cfg_data;
                CFG_SELF_BOX_MAX:      cfg_max_reg      <= cfg_data;
                CFG_SELF_SCALE:        cfg_scale_reg    <= cfg_data;
                CFG_SELF_POSITION:     cfg_pos_reg      <= cfg_data;
                CFG_SELF_HAS_COLLIDER: cfg_collider_reg <= cfg_data[0];
                CFG_SELF_IS_WALL:      cfg_wall_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        valid_next = (stage_en & {valid_reg[NUM_STAGES-2:0], item.valid})
                   | (~stage_en & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign item.ready   = stage_en[0];
    assign result.valid = valid_reg[NUM_STAGES-1];

    assign flags_in.hit_en  = cfg_collider_reg && item.other_has_collider && !item.other_is_self;
    assign flags_in.push_en = cfg_wall_reg && !item.other_is_wall;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            flags1_reg <= flags_in;
        if (stage_en[1])
            flags2_reg <= flags1_reg;
    end

    aabb_xform #(.COORD_BITS(COORD_BITS)) u_xform_self (
        .clk      (clk),
        .en1      (stage_en[0]),
        .en2      (stage_en[1]),
        .box_min  (cfg_min_reg),
        .box_max  (cfg_max_reg),
        .scale    (cfg_scale_reg),
        .position (cfg_pos_reg),
        .wmin     (smin),
        .wmax     (smax),
        .pos      (spos)
    );

    aabb_xform #(.COORD_BITS(COORD_BITS)) u_xform_other (
        .clk      (clk),
        .en1      (stage_en[0]),
        .en2      (stage_en[1]),
        .box_min  (item.other_box_min),
        .box_max  (item.other_box_max),
        .scale    (item.other_scale),
        .position (item.other_position),
        .wmin     (omin),
        .wmax     (omax),
        .pos      (opos)
    );

    aabb_ovl #(.COORD_BITS(COORD_BITS)) u_ovl (
        .clk     (clk),
        .en3     (stage_en[2]),
        .en4     (stage_en[3]),
        .flags   (flags2_reg),
        .smin    (smin),
        .smax    (smax),
        .omin    (omin),
        .omax    (omax),
        .pos_in  (opos),
        .best    (best),
        .cgt     (cgt),
        .hit     (hit4),
        .push    (push4),
        .pos_out (pos4)
    );

    aabb_push #(.COORD_BITS(COORD_BITS)) u_push (
        .clk       (clk),
        .en5       (stage_en[4]),
        .en6       (stage_en[5]),
        .best      (best),
        .cgt       (cgt),
        .hit_in    (hit4),
        .push_in   (push4),
        .pos_in    (pos4),
        .hit       (result.hit),
        .pushed    (result.pushed),
        .push_axis (axis_out),
        .new_pos_x (result.new_pos_x),
        .new_pos_y (result.new_pos_y),
        .new_pos_z (result.new_pos_z)
    );

    assign result.push_axis = axis_out;

    `AABB_ASSERT_NOW(a_push_needs_hit, result.valid && result.pushed, result.hit, "push without hit")
    `AABB_ASSERT_NOW(a_axis_needs_push, result.valid && result.push_axis != AXIS_X, result.pushed, "axis set without push")
    `AABB_ASSERT_NOW(a_full_when_blocked, !item.ready, &valid_reg, "input blocked with a free stage")
    `AABB_ASSERT_NEXT(a_word_count, item.valid && item.ready && !(result.valid && result.ready), $countones(valid_reg) == $past($countones(valid_reg)) + 1, "word lost in pipeline")

endmodule

`default_nettype wire

[tb/sv/tb_aabb_collision_push_out_core.sv]
// Testbench for the box collision push-out core: predicts each result word and checks it
`timescale 1ns / 1ps

module tb_aabb_collision_push_out_core;
    import aabb_pkg::*;

    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct {
        logic [FIELD_W-1:0] bmin;
        logic [FIELD_W-1:0] bmax;
        logic [FIELD_W-1:0] scale;
        logic [FIELD_W-1:0] pos;
        logic               collider;
        logic               wall;
        logic               is_self;
    } object_t;

    typedef struct {
        logic                 hit;
        logic                 pushed;
        logic [1:0]           axis;
        logic [POS_OUT_W-1:0] x;
        logic [POS_OUT_W-1:0] y;
        logic [POS_OUT_W-1:0] z;
    } outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    aabb_in_if  item_ch ();
    aabb_out_if result_ch ();

    aabb_collision_push_out_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    logic [FIELD_W-1:0] self_min;
    logic [FIELD_W-1:0] self_max;
    logic [FIELD_W-1:0] self_scale;
    logic [FIELD_W-1:0] self_pos;
    logic               self_collider;
    logic               self_wall;

    outcome_t pending_outcomes[$];

    int  error_count        = 0;
    int  objects_sent       = 0;
    int  results_checked    = 0;
    int  hits_seen          = 0;
    int  pushes_seen        = 0;
    int  configs_loaded     = 0;
    int  input_stall_cycles = 0;
    int  burst_left         = 0;
    bit  steady_send        = 0;
    bit  hold_req           = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [FIELD_W-1:0] pack3(input logic [15:0] x, y, z);
        return {z, y, x};
    endfunction

    function automatic longint coord(input logic [FIELD_W-1:0] v, input int a);
        logic signed [15:0] c;
        c = v[a*16 +: 16];
        return c;
    endfunction

    function automatic void world_span(input logic [FIELD_W-1:0] mn, mx, sc, ps,
                                       input int a, output longint lo, output longint hi);
        lo = ((coord(mn, a) * coord(sc, a)) >>> FRAC_BITS) + coord(ps, a);
        hi = ((coord(mx, a) * coord(sc, a)) >>> FRAC_BITS) + coord(ps, a);
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic outcome_t predict_push_out(input object_t o);
        longint   smin[3], smax[3], omin[3], omax[3], pos[3];
        longint   best, ov;
        int       a, c, ai;
        outcome_t r;
        for (a = 0; a < 3; a++)
        begin
            world_span(self_min, self_max, self_scale, self_pos, a, smin[a], smax[a]);
            world_span(o.bmin, o.bmax, o.scale, o.pos, a, omin[a], omax[a]);
            pos[a] = coord(o.pos, a);
        end
        r.hit = self_collider && o.collider && !o.is_self;
        for (a = 0; a < 3; a++)
            if (smax[a] < omin[a] || smin[a] > omax[a])
                r.hit = 1'b0;
        r.pushed = r.hit && self_wall && !o.wall;
        ai = 0;
        if (r.pushed)
        begin
            best = smax[0] - omin[0];
            for (c = 1; c < 6; c++)
            begin
                a  = c / 2;
                ov = (c % 2) ? omax[a] - smin[a] : smax[a] - omin[a];
                if (ov < best)
                begin
                    best = ov;
                    ai   = a;
                end
            end
            if ((omin[ai] + omax[ai]) - (smin[ai] + smax[ai]) > 0)
                pos[ai] = pos[ai] + best;
            else
                pos[ai] = pos[ai] - best;
        end
        r.axis = axis_t'(ai);
        r.x    = clamp16(pos[0]);
        r.y    = clamp16(pos[1]);
        r.z    = clamp16(pos[2]);
        return r;
    endfunction

    function automatic logic [15:0] pick_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'h0100;
        if (r < 8)
            return 16'($urandom_range(32, 768));
        if (r == 8)
            return 16'(0 - $urandom_range(32, 768));
        return 16'($urandom);
    endfunction

    function automatic object_t unit_object(input logic [15:0] px, py, pz);
        object_t o;
        o.bmin     = pack3(16'hFF00, 16'hFF00, 16'hFF00);
        o.bmax     = pack3(16'h0100, 16'h0100, 16'h0100);
        o.scale    = pack3(16'h0100, 16'h0100, 16'h0100);
        o.pos      = pack3(px, py, pz);
        o.collider = 1'b1;
        o.wall     = 1'b0;
        o.is_self  = 1'b0;
        return o;
    endfunction

    // mostly objects placed around the fixed box, some broken, some pure noise
    function automatic object_t make_object();
        object_t            o;
        longint             lo, hi, centre, reach;
        int                 shape, a;
        logic [FIELD_W-1:0] t;
        shape      = $urandom_range(0, 19);
        o.collider = $urandom_range(0, 9) != 0;
        o.wall     = $urandom_range(0, 4) == 0;
        o.is_self  = $urandom_range(0, 11) == 0;
        if (shape >= 18)
        begin
            o.bmin  = 48'({$urandom, $urandom});
            o.bmax  = 48'({$urandom, $urandom});
            o.scale = 48'({$urandom, $urandom});
            o.pos   = 48'({$urandom, $urandom});
            return o;
        end
        for (a = 0; a < 3; a++)
        begin
            world_span(self_min, self_max, self_scale, self_pos, a, lo, hi);
            centre = (lo + hi) >>> 1;
            reach  = ((hi > lo) ? hi - lo : lo - hi) / 2 + 768;
            if (reach > 40000)
                reach = 40000;
            o.bmin[a*16 +: 16]  = 16'(0 - $urandom_range(0, 768));
            o.bmax[a*16 +: 16]  = 16'($urandom_range(0, 768));
            o.scale[a*16 +: 16] = pick_scale();
            o.pos[a*16 +: 16]   = 16'(centre - reach + longint'($urandom_range(0, 32'(2 * reach))));
        end
        if (shape >= 16)
        begin
            a = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0:
                begin
                    t      = o.bmin;
                    o.bmin = o.bmax;
                    o.bmax = t;
                end
                1:
                begin
                    o.bmin[a*16 +: 16] = 16'h8000;
                    o.bmax[a*16 +: 16] = 16'h7FFF;
                end
                default:
                    o.pos[a*16 +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            endcase
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(want_v), $signed(got_v));
            error_count++;
        end
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        item_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_outcomes.size() != 0)
        begin
            $error("%0d result words never arrived", pending_outcomes.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        case (r)
            CFG_SELF_BOX_MIN:      self_min      = d;
            CFG_SELF_BOX_MAX:      self_max      = d;
            CFG_SELF_SCALE:        self_scale    = d;
            CFG_SELF_POSITION:     self_pos      = d;
            CFG_SELF_HAS_COLLIDER: self_collider = d[0];
            CFG_SELF_IS_WALL:      self_wall     = d[0];
            default:               ;
        endcase
    endtask

    task automatic load_self(input logic [FIELD_W-1:0] mn, mx, sc, ps,
                             input logic col, input logic wall);
        logic [CFG_DATA_W-1:0] junk;
        settle();
        junk = 48'({$urandom, $urandom});
        write_reg(CFG_SELF_BOX_MIN, mn);
        write_reg(CFG_SELF_BOX_MAX, mx);
        write_reg(CFG_SELF_SCALE, sc);
        write_reg(CFG_SELF_POSITION, ps);
        write_reg(CFG_SELF_HAS_COLLIDER, {junk[CFG_DATA_W-1:1], col});
        write_reg(CFG_SELF_IS_WALL, {junk[CFG_DATA_W-2:0], wall});
        cfg_we <= 1'b0;
        @(posedge clk);
        configs_loaded++;
    endtask

    task automatic load_random_self(input logic col, input logic wall);
        logic [FIELD_W-1:0] mn, mx, sc, ps;
        int                 a;
        for (a = 0; a < 3; a++)
        begin
            mn[a*16 +: 16] = 16'(0 - $urandom_range(0, 1024));
            mx[a*16 +: 16] = 16'($urandom_range(0, 1024));
            sc[a*16 +: 16] = pick_scale();
            if ($urandom_range(0, 4) == 0)
                ps[a*16 +: 16] = $urandom_range(0, 1) ? 16'(32'h7800 + $urandom_range(0, 2047))
                                                      : 16'(32'h8000 + $urandom_range(0, 2047));
            else
                ps[a*16 +: 16] = 16'($urandom_range(0, 8191) - 4096);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            mn = 48'({$urandom, $urandom});
            mx = 48'({$urandom, $urandom});
            sc = 48'({$urandom, $urandom});
        end
        load_self(mn, mx, sc, ps, col, wall);
    endtask

    task automatic send_object(input object_t o);
        int gap;
        if (!steady_send && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid              <= 1'b1;
        item_ch.other_box_min      <= o.bmin;
        item_ch.other_box_max      <= o.bmax;
        item_ch.other_scale        <= o.scale;
        item_ch.other_position     <= o.pos;
        item_ch.other_has_collider <= o.collider;
        item_ch.other_is_wall      <= o.wall;
        item_ch.other_is_self      <= o.is_self;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_outcomes.push_back(predict_push_out(o));
        objects_sent++;
    endtask

    task automatic test_reset_defaults();
        repeat (8) send_object(make_object());
    endtask

    task automatic test_directed();
        object_t o;
        load_self(pack3(16'hFF00, 16'hFF00, 16'hFF00), pack3(16'h0100, 16'h0100, 16'h0100),
                  pack3(16'h0100, 16'h0100, 16'h0100), '0, 1'b1, 1'b1);
        send_object(unit_object(16'h0000, 16'h0000, 16'h0000));
        send_object(unit_object(16'h0180, 16'h0000, 16'h0000));
        send_object(unit_object(16'hFE80, 16'h0000, 16'h0000));
        send_object(unit_object(16'h0000, 16'h0140, 16'h0000));
        send_object(unit_object(16'h0000, 16'hFEC0, 16'h0000));
        send_object(unit_object(16'h0000, 16'h0000, 16'h01C0));
        send_object(unit_object(16'h0000, 16'h0000, 16'hFE40));
        send_object(unit_object(16'h0100, 16'h0100, 16'h0000));
        send_object(unit_object(16'h0200, 16'h0000, 16'h0000));
        send_object(unit_object(16'h0201, 16'h0000, 16'h0000));
        o = unit_object(16'h0000, 16'h0000, 16'h0000);
        o.is_self = 1'b1;
        send_object(o);
        o = unit_object(16'h0000, 16'h0000, 16'h0000);
        o.collider = 1'b0;
        send_object(o);
        o = unit_object(16'h0040, 16'h0000, 16'h0000);
        o.wall = 1'b1;
        send_object(o);
        o = unit_object(16'h0080, 16'h0000, 16'h0000);
        o.bmin[31:16] = 16'h0100;
        o.bmax[31:16] = 16'hFF00;
        send_object(o);
        o = unit_object(16'h7FF0, 16'h0000, 16'h0000);
        o.bmin[15:0] = 16'h8000;
        send_object(o);
        o = unit_object(16'h8010, 16'h0000, 16'h0000);
        o.bmax[15:0] = 16'h7FFF;
        send_object(o);
        o = unit_object(16'h0000, 16'h0000, 16'h7FF0);
        o.bmin[47:32] = 16'h8000;
        send_object(o);
        o = unit_object(16'h0000, 16'h0000, 16'h0000);
        o.scale = pack3(16'h8000, 16'h7FFF, 16'h8000);
        o.bmin  = pack3(16'h8000, 16'h8000, 16'h7FFF);
        o.bmax  = pack3(16'h7FFF, 16'h7FFF, 16'h8000);
        send_object(o);
        o = unit_object(16'h0000, 16'h0000, 16'h0000);
        o.scale = '0;
        send_object(o);
        o.bmin     = '1;
        o.bmax     = '1;
        o.scale    = '1;
        o.pos      = '1;
        o.collider = 1'b1;
        o.wall     = 1'b1;
        o.is_self  = 1'b1;
        send_object(o);
        o.bmin     = '0;
        o.bmax     = '0;
        o.scale    = '0;
        o.pos      = '0;
        o.collider = 1'b0;
        o.wall     = 1'b0;
        o.is_self  = 1'b0;
        send_object(o);
    endtask

    task automatic test_flag_combinations();
        int f;
        for (f = 0; f < 4; f++)
        begin
            load_random_self(f[0], f[1]);
            repeat (40) send_object(make_object());
        end
    endtask

    task automatic test_extreme_configs();
        load_self('1, '1, '1, '1, 1'b1, 1'b1);
        repeat (45) send_object(make_object());
        load_self(pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                  pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                  1'b1, 1'b1);
        repeat (45) send_object(make_object());
        load_self(pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), pack3(16'h8000, 16'h8000, 16'h8000),
                  pack3(16'h8000, 16'h8000, 16'h8000), pack3(16'h8000, 16'h8000, 16'h8000),
                  1'b1, 1'b1);
        repeat (45) send_object(make_object());
        load_self(pack3(16'hFF00, 16'hFF00, 16'hFF00), pack3(16'h0100, 16'h0100, 16'h0100),
                  '0, '0, 1'b1, 1'b1);
        repeat (45) send_object(make_object());
    endtask

    task automatic test_back_pressure();
        load_random_self(1'b1, 1'b1);
        steady_send = 1;
        hold_req    = 1;
        repeat (80) send_object(make_object());
        steady_send = 0;
    endtask

    task automatic test_random_scenes();
        int s;
        for (s = 0; s < 8; s++)
        begin
            load_random_self($urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0);
            steady_send = (s == 3);
            repeat (125) send_object(make_object());
        end
        steady_send = 0;
    endtask

    initial
    begin : result_receiver
        int run_left;
        int mode;
        run_left = 0;
        mode     = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            if (run_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                run_left = $urandom_range(10, 120);
            end
            run_left--;
            case (mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                default: result_ch.ready <= ((run_left % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_checker
        outcome_t want;
        if (rst_n)
        begin
            if (item_ch.valid && !item_ch.ready)
                input_stall_cycles++;
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result word with no object waiting");
                    error_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("hit", 16'(want.hit), 16'(result_ch.hit));
                    check_field("pushed", 16'(want.pushed), 16'(result_ch.pushed));
                    check_field("push_axis", 16'(want.axis), 16'(result_ch.push_axis));
                    check_field("new_pos_x", want.x, result_ch.new_pos_x);
                    check_field("new_pos_y", want.y, result_ch.new_pos_y);
                    check_field("new_pos_z", want.z, result_ch.new_pos_z);
                    results_checked++;
                    hits_seen   += want.hit;
                    pushes_seen += want.pushed;
                end
            end
        end
    end

    initial
    begin : run_tests
        rst_n                      <= 1'b0;
        cfg_we                     <= 1'b0;
        cfg_index                  <= CFG_SELF_BOX_MIN;
        cfg_data                   <= '0;
        item_ch.valid              <= 1'b0;
        item_ch.other_box_min      <= '0;
        item_ch.other_box_max      <= '0;
        item_ch.other_scale        <= '0;
        item_ch.other_position     <= '0;
        item_ch.other_has_collider <= 1'b0;
        item_ch.other_is_wall      <= 1'b0;
        item_ch.other_is_self      <= 1'b0;
        self_min      = '0;
        self_max      = '0;
        self_scale    = '0;
        self_pos      = '0;
        self_collider = 1'b0;
        self_wall     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_flag_combinations();
        test_extreme_configs();
        test_back_pressure();
        test_random_scenes();
        settle();

        $display("Sent %0d objects against %0d fixed-box settings: %0d hits, %0d pushed out",
                 objects_sent, configs_loaded, hits_seen, pushes_seen);
        $display("Checked %0d result words, input held off for %0d cycles, %0d errors",
                 results_checked, input_stall_cycles, error_count);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/aabb_pkg.sv
src/aabb_if.sv
src/aabb_xform.sv
src/aabb_ovl.sv
src/aabb_push.sv
src/aabb_collision_push_out_core.sv
tb/sv/tb_aabb_collision_push_out_core.sv
